// ===== rtl/rc_failsafe_and_stick_mapper_assert.svh =====
// ----------------------------------------------------------------------------
// rc failsafe and stick mapper assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef RC_FAILSAFE_AND_STICK_MAPPER_ASSERT_SVH
`define RC_FAILSAFE_AND_STICK_MAPPER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define RCFS_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCFS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rcfs_pkg.sv =====
// ----------------------------------------------------------------------------
// rcfs_pkg
// shared types and constants of the rc failsafe and stick mapper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcfs_pkg;

    // failsafe phase codes
    typedef enum logic [1:0] {
        PHASE_IDLE = 2'd0,
        PHASE_LOSS = 2'd1,
        PHASE_OFF  = 2'd2
    } phase_t;

    // operand selection of the shared multiplier
    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_ROLL  = 3'd1,
        MUL_PITCH = 3'd2,
        MUL_YAWK  = 3'd3,
        MUL_YAWF  = 3'd4
    } mul_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load_in;
        mul_op_t mul_op;
        logic    cap_roll;
        logic    cap_pitch;
        logic    cap_f;
        logic    cap_yaw;
        logic    eval;
        logic    commit;
    } rcfs_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic is_check;
        logic out_free;
    } rcfs_status_t;

    // configuration register indexes
    localparam logic [7:0] CFG_LOSS_THRESHOLD      = 8'd0;
    localparam logic [7:0] CFG_SWITCHOFF_THRESHOLD = 8'd1;
    localparam logic [7:0] CFG_ROLL_MAX_ANGLE      = 8'd2;
    localparam logic [7:0] CFG_PITCH_MAX_ANGLE     = 8'd3;

    // configuration reset values
    localparam logic [31:0] LOSS_THRESHOLD_RST      = 32'd1500;
    localparam logic [31:0] SWITCHOFF_THRESHOLD_RST = 32'd3000;
    localparam logic [15:0] MAX_ANGLE_RST           = 16'd5120;

    // input action codes
    localparam logic ACTION_PACKET = 1'b0;
    localparam logic ACTION_CHECK  = 1'b1;

    // yaw curve constants: 0.2 in q0.16, 1.0 in q1.15
    localparam logic signed [17:0] YAW_ALPHA_Q16 = 18'sd13107;
    localparam logic [16:0]        ONE_Q15       = 17'd32768;

endpackage

// ===== rtl/rcfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rcfs_ctrl
// sequencer that steps one item through the shared multiplier datapath
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfs_ctrl
    import rcfs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  rcfs_status_t status,
    output rcfs_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_PITCH,
        ST_YAWK,
        ST_YAWF,
        ST_YAWM,
        ST_YAWR,
        ST_OUT
    } state_t;

    state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_NONE;
        case (state_reg)
            ST_IDLE: begin
                cmd.load_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
                if (status.is_check) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.mul_op = MUL_ROLL;
                    state_next = ST_PITCH;
                end
            end
            ST_PITCH: begin
                cmd.cap_roll = 1'b1;
                cmd.mul_op   = MUL_PITCH;
                state_next   = ST_YAWK;
            end
            ST_YAWK: begin
                cmd.cap_pitch = 1'b1;
                cmd.mul_op    = MUL_YAWK;
                state_next    = ST_YAWF;
            end
            ST_YAWF: begin
                cmd.cap_f  = 1'b1;
                state_next = ST_YAWM;
            end
            ST_YAWM: begin
                cmd.mul_op = MUL_YAWF;
                state_next = ST_YAWR;
            end
            ST_YAWR: begin
                cmd.cap_yaw = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                cmd.commit = status.out_free;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rcfs_dp.sv =====
// ----------------------------------------------------------------------------
// rcfs_dp
// input capture, config registers, shared multiplier, failsafe state, output beat
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfs_dp
    import rcfs_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    // input beat
    input  logic [103:0]  s_tdata,
    input  logic          s_tuser,
    // config write
    input  logic          cfg_valid,
    input  logic [7:0]    cfg_index,
    input  logic [31:0]   cfg_data,
    // output beat
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [103:0]  m_tdata,
    output logic          m_tuser,
    // control
    input  rcfs_cmd_t     cmd,
    output rcfs_status_t  status
);

    // config registers
    logic [31:0] loss_thr_reg;
    logic [31:0] off_thr_reg;
    logic [15:0] roll_ang_reg;
    logic [15:0] pitch_ang_reg;

    // captured input beat
    logic               action_reg;
    logic [31:0]        tick_reg;
    logic signed [15:0] thr_reg;
    logic signed [15:0] roll_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] yaw_reg;
    logic               sw_reg;

    // failsafe state
    phase_t      phase_reg, phase_next;
    logic [31:0] last_tick_reg;
    logic        held_reg, held_next;
    logic        motors_reg, motors_next;

    // check decision flags
    logic gate_reg;
    logic below_reg;

    // multiplier and partial results
    logic signed [17:0] op_a, op_b;
    logic signed [35:0] prod_reg;
    logic signed [16:0] roll_res_reg;
    logic signed [16:0] pitch_res_reg;
    logic [16:0]        f_reg;
    logic signed [15:0] yaw_res_reg;

    // output register
    logic         m_tvalid_reg;
    logic [103:0] m_tdata_reg;
    logic         m_tuser_reg;

    logic [31:0]        gap;
    logic [16:0]        yaw_abs;
    logic [16:0]        yaw_d;
    logic signed [35:0] rnd15;
    logic signed [35:0] rnd16;
    logic signed [20:0] sh15;
    logic signed [16:0] ang_sat;
    logic signed [15:0] yaw_sat;
    logic [12:0]        k_val;
    logic               out_valid;
    logic [31:0]        out_tick;
    logic signed [15:0] out_thr;
    logic signed [16:0] out_roll;
    logic signed [16:0] out_pitch;
    logic signed [15:0] out_yaw;

    assign status.is_check = (action_reg == ACTION_CHECK);
    assign status.out_free = !m_tvalid_reg || m_tready;

    // config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loss_thr_reg  <= LOSS_THRESHOLD_RST;
            off_thr_reg   <= SWITCHOFF_THRESHOLD_RST;
            roll_ang_reg  <= MAX_ANGLE_RST;
            pitch_ang_reg <= MAX_ANGLE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_LOSS_THRESHOLD:      loss_thr_reg  <= cfg_data;
                CFG_SWITCHOFF_THRESHOLD: off_thr_reg   <= cfg_data;
                CFG_ROLL_MAX_ANGLE:      roll_ang_reg  <= cfg_data[15:0];
                CFG_PITCH_MAX_ANGLE:     pitch_ang_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            action_reg <= s_tuser;
            tick_reg   <= s_tdata[31:0];
            thr_reg    <= s_tdata[47:32];
            roll_reg   <= s_tdata[63:48];
            pitch_reg  <= s_tdata[79:64];
            yaw_reg    <= s_tdata[95:80];
            sw_reg     <= s_tdata[96];
        end
    end

    // yaw magnitude and distance from full scale
    always_comb begin
        yaw_abs = yaw_reg[15] ? 17'(-{yaw_reg[15], yaw_reg}) : {1'b0, yaw_reg};
        yaw_d   = ONE_Q15 - yaw_abs;
    end

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        case (cmd.mul_op)
            MUL_ROLL: begin
                op_a = {{2{roll_reg[15]}}, roll_reg};
                op_b = {2'b00, roll_ang_reg};
            end
            MUL_PITCH: begin
                op_a = {{2{pitch_reg[15]}}, pitch_reg};
                op_b = {2'b00, pitch_ang_reg};
            end
            MUL_YAWK: begin
                op_a = YAW_ALPHA_Q16;
                op_b = {1'b0, yaw_d};
            end
            MUL_YAWF: begin
                op_a = {{2{yaw_reg[15]}}, yaw_reg};
                op_b = {1'b0, f_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_op != MUL_NONE) begin
            prod_reg <= op_a * op_b;
        end
    end

    // rounding and saturation of the registered product
    always_comb begin
        rnd15 = prod_reg + 36'sd16384;
        rnd16 = prod_reg + 36'sd32768;
        sh15  = rnd15[35:15];
        k_val = rnd16[28:16];
        if (sh15 > 21'sd65535) begin
            ang_sat = 17'sd65535;
        end else if (sh15 < -21'sd65536) begin
            ang_sat = -17'sd65536;
        end else begin
            ang_sat = sh15[16:0];
        end
        if (sh15 > 21'sd32767) begin
            yaw_sat = 16'sd32767;
        end else if (sh15 < -21'sd32768) begin
            yaw_sat = -16'sd32768;
        end else begin
            yaw_sat = sh15[15:0];
        end
    end

    // partial result capture
    always_ff @(posedge aclk) begin
        if (cmd.cap_roll) begin
            roll_res_reg <= ang_sat;
        end
        if (cmd.cap_pitch) begin
            pitch_res_reg <= ang_sat;
        end
        if (cmd.cap_f) begin
            f_reg <= ONE_Q15 - {4'b0000, k_val};
        end
        if (cmd.cap_yaw) begin
            yaw_res_reg <= yaw_sat;
        end
    end

    // failsafe check against both thresholds
    assign gap = tick_reg - last_tick_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            gate_reg  <= (gap > loss_thr_reg) && (phase_reg != PHASE_OFF);
            below_reg <= (gap < off_thr_reg);
        end
    end

    // next failsafe state and result fields
    always_comb begin
        phase_next  = phase_reg;
        held_next   = held_reg;
        motors_next = motors_reg;
        out_valid   = 1'b0;
        out_tick    = '0;
        out_thr     = '0;
        out_roll    = '0;
        out_pitch   = '0;
        out_yaw     = '0;
        if (action_reg == ACTION_PACKET) begin
            phase_next = PHASE_IDLE;
            if (sw_reg) begin
                held_next = 1'b1;
            end else if (held_reg) begin
                motors_next = !motors_reg;
                held_next   = 1'b0;
            end
            out_valid = 1'b1;
            out_tick  = tick_reg;
            out_thr   = thr_reg;
            out_roll  = roll_res_reg;
            out_pitch = pitch_res_reg;
            out_yaw   = yaw_res_reg;
        end else if (gate_reg) begin
            if (below_reg) begin
                phase_next = PHASE_LOSS;
                out_valid  = 1'b1;
                out_tick   = tick_reg;
            end else begin
                phase_next  = PHASE_OFF;
                motors_next = 1'b0;
            end
        end
    end

    // state update on commit
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PHASE_OFF;
            last_tick_reg <= '0;
            held_reg      <= 1'b0;
            motors_reg    <= 1'b0;
        end else if (cmd.commit) begin
            phase_reg  <= phase_next;
            held_reg   <= held_next;
            motors_reg <= motors_next;
            if (action_reg == ACTION_PACKET) begin
                last_tick_reg <= tick_reg;
            end
        end
    end

    // output beat register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_tuser_reg <= out_valid;
            m_tdata_reg <= {3'b000, phase_next, motors_next, out_yaw, out_pitch,
                            out_roll, out_thr, out_tick};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/rc_failsafe_and_stick_mapper.sv =====
// ----------------------------------------------------------------------------
// rc_failsafe_and_stick_mapper
// radio packet failsafe tracking and stick to setpoint mapping
// ----------------------------------------------------------------------------
// Each input beat is a radio packet (tuser 0) or a failsafe check (tuser 1) and
// yields exactly one output beat. A packet passes the states EVAL, PITCH, YAWK,
// YAWF, YAWM, YAWR and OUT on its way to the output register: its four products
// (roll, pitch, and two for the yaw curve) go one after another through a single
// 18x18 multiplier. A check passes EVAL and OUT, one wide subtract and compare
// against both thresholds. OUT waits until the output register is free. A new
// beat is accepted only after the previous one has been moved to the output
// register, so the output may still hold an untaken result. Config writes are
// accepted every cycle and should only be issued while the block is idle.
`timescale 1ns / 1ps

module rc_failsafe_and_stick_mapper
    import rcfs_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // tick_count[31:0], throttle_stick[47:32], roll_stick[63:48],
    // pitch_stick[79:64], yaw_stick[95:80], onoff_switch[96], zero fill
    input  logic [103:0] s_tdata,
    // action[0]
    input  logic         s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // setpoint_tick[31:0], throttle_out[47:32], roll_degrees[64:48],
    // pitch_degrees[81:65], yaw_rate[97:82], motors_enabled[98],
    // failsafe_phase[100:99], zero fill
    output logic [103:0] m_tdata,
    // setpoint_valid[0]
    output logic         m_tuser,
    // config write
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

`include "rc_failsafe_and_stick_mapper_assert.svh"

    rcfs_cmd_t    cmd;
    rcfs_status_t status;

    assign cfg_ready = 1'b1;

    // sequencer
    rcfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath
    rcfs_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .status    (status)
    );

    // checks
    `RCFS_ASSERT_SAME(a_off_no_setpoint, aclk, aresetn, m_tvalid && (m_tdata[100:99] == PHASE_OFF), !m_tuser, "setpoints issued while switched off")
    `RCFS_ASSERT_SAME(a_empty_beat_zero, aclk, aresetn, m_tvalid && !m_tuser, m_tdata[97:0] == '0, "setpoint fields not zero without setpoints")
    `RCFS_ASSERT_SAME(a_busy_no_accept, aclk, aresetn, cmd.mul_op != MUL_NONE, !s_tready, "input accepted while multiplier busy")
    `RCFS_ASSERT_NEXT(a_commit_shows_beat, aclk, aresetn, cmd.commit, m_tvalid, "committed result not presented")

endmodule

// ===== verif/tb_rc_failsafe_and_stick_mapper.sv =====
// ----------------------------------------------------------------------------
// tb_rc_failsafe_and_stick_mapper
// self-checking bench for the rc failsafe and stick mapper
// ----------------------------------------------------------------------------
// A directed table covers reset behavior, stick extremes, the loss and
// switch-off boundaries, tick wrap and the switch release toggle. After it come
// several register settings, each followed by random packet/check traffic built
// around the thresholds. Every accepted input beat is run through a local
// model of the failsafe state and the stick arithmetic, and each output beat is
// compared field by field in arrival order. Both stream sides idle at random,
// the receiver once holds off long enough to back up the input, and the
// register writes wait until every pending result has been taken.
`timescale 1ns / 1ps

module tb_rc_failsafe_and_stick_mapper;
    import rcfs_pkg::*;

    // 0.2 in q0.16, taper of the yaw curve
    localparam longint YAW_TAPER_Q16 = 13107;
    // first register index that maps to nothing
    localparam logic [7:0] CFG_FIRST_UNMAPPED = 8'd4;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic               action;
        logic [31:0]        tick;
        logic signed [15:0] thr;
        logic signed [15:0] roll;
        logic signed [15:0] pitch;
        logic signed [15:0] yaw;
        logic               sw;
    } rc_beat_t;

    typedef struct packed {
        logic               valid;
        logic [31:0]        tick;
        logic signed [15:0] thr;
        logic signed [16:0] roll;
        logic signed [16:0] pitch;
        logic signed [15:0] yaw;
        logic               motors;
        phase_t             phase;
    } setpoint_t;

    typedef struct packed {
        rc_beat_t  beat;
        logic      typed;
        setpoint_t want;
    } dir_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;
    logic         s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    logic         m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [31:0]  cfg_data;

    rc_failsafe_and_stick_mapper DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // local copy of the registers
    logic [31:0] loss_thr;
    logic [31:0] off_thr;
    logic [15:0] roll_full;
    logic [15:0] pitch_full;

    // local copy of the failsafe state
    phase_t      fs_phase;
    logic [31:0] last_pkt_tick;
    logic        sw_latched;
    logic        motors_on;

    setpoint_t   setpoint_q[$];
    dir_row_t    dir_tab[$];
    int          mismatches;
    logic [31:0] cur_tick;
    bit          calm;
    bit          long_hold_req;

    // clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stick times q8.8 angle, rounded and saturated to 17 bits
    function automatic logic signed [16:0] scale_stick(logic signed [15:0] s,
                                                       logic [15:0] ang);
        longint p;
        p = longint'(s) * longint'({48'd0, ang});
        p = (p + 16384) >>> 15;
        if (p < -65536) p = -65536;
        if (p > 65535) p = 65535;
        return p[16:0];
    endfunction

    // yaw curve s*(1 - 0.2*(1 - |s|)) in q1.15
    function automatic logic signed [15:0] curve_yaw(logic signed [15:0] s);
        longint sv;
        longint mag;
        longint taper;
        longint y;
        sv = longint'(s);
        mag = (sv < 0) ? -sv : sv;
        taper = (YAW_TAPER_Q16 * (32768 - mag) + 32768) >>> 16;
        y = (sv * (32768 - taper) + 16384) >>> 15;
        if (y < -32768) y = -32768;
        if (y > 32767) y = 32767;
        return y[15:0];
    endfunction

    // advance the failsafe state by one beat and form its result
    function automatic setpoint_t predict_setpoints(rc_beat_t b);
        setpoint_t   r;
        logic [31:0] gap;
        r = '0;
        if (b.action == ACTION_PACKET) begin
            fs_phase = PHASE_IDLE;
            last_pkt_tick = b.tick;
            if (b.sw) begin
                sw_latched = 1'b1;
            end else if (sw_latched) begin
                motors_on = !motors_on;
                sw_latched = 1'b0;
            end
            r.valid = 1'b1;
            r.tick  = b.tick;
            r.thr   = b.thr;
            r.roll  = scale_stick(b.roll, roll_full);
            r.pitch = scale_stick(b.pitch, pitch_full);
            r.yaw   = curve_yaw(b.yaw);
        end else begin
            gap = b.tick - last_pkt_tick;
            if (gap > loss_thr && fs_phase != PHASE_OFF) begin
                if (gap < off_thr) begin
                    fs_phase = PHASE_LOSS;
                    r.valid = 1'b1;
                    r.tick = b.tick;
                end else begin
                    fs_phase = PHASE_OFF;
                    motors_on = 1'b0;
                end
            end
        end
        r.motors = motors_on;
        r.phase  = fs_phase;
        return r;
    endfunction

    function automatic rc_beat_t mk_beat(logic action, logic [31:0] tick, int thr, int roll,
                                         int pitch, int yaw, int sw);
        rc_beat_t b;
        b.action = action;
        b.tick   = tick;
        b.thr    = thr[15:0];
        b.roll   = roll[15:0];
        b.pitch  = pitch[15:0];
        b.yaw    = yaw[15:0];
        b.sw     = sw[0];
        return b;
    endfunction

    function automatic setpoint_t mk_sp(int valid, logic [31:0] tick, int thr, int roll,
                                        int pitch, int yaw, int motors, phase_t phase);
        setpoint_t r;
        r.valid  = valid[0];
        r.tick   = tick;
        r.thr    = thr[15:0];
        r.roll   = roll[16:0];
        r.pitch  = pitch[16:0];
        r.yaw    = yaw[15:0];
        r.motors = motors[0];
        r.phase  = phase;
        return r;
    endfunction

    task automatic row(rc_beat_t b, logic typed, setpoint_t want);
        dir_row_t r;
        r.beat  = b;
        r.typed = typed;
        r.want  = want;
        dir_tab.push_back(r);
    endtask

    // stick value, often a corner
    function automatic int draw_stick();
        case ($urandom_range(0, 7))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 2) - 1;
            default: return $urandom;
        endcase
    endfunction

    // offer one beat and hold it until taken; the expectation is formed on accept
    task automatic send_beat(rc_beat_t b, logic typed, setpoint_t want);
        setpoint_t pred;
        s_tvalid <= 1'b1;
        s_tuser  <= b.action;
        s_tdata  <= {7'd0, b.sw, b.yaw, b.pitch, b.roll, b.thr, b.tick};
        do @(posedge aclk); while (!s_tready);
        pred = predict_setpoints(b);
        setpoint_q.push_back(typed ? want : pred);
    endtask

    // random sender gap
    task automatic sender_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (setpoint_q.size() != 0) @(posedge aclk);
    endtask

    // one register write; the caller lowers cfg_valid after the batch
    task automatic cfg_write(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_LOSS_THRESHOLD:      loss_thr   = val;
            CFG_SWITCHOFF_THRESHOLD: off_thr    = val;
            CFG_ROLL_MAX_ANGLE:      roll_full  = val[15:0];
            CFG_PITCH_MAX_ANGLE:     pitch_full = val[15:0];
            default: ;
        endcase
    endtask

    // random traffic shaped around the current thresholds
    task automatic run_random(int count);
        rc_beat_t    b;
        logic [31:0] gap;
        int          pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            b = mk_beat(ACTION_PACKET, 32'd0, draw_stick(), draw_stick(), draw_stick(),
                        draw_stick(), $urandom_range(0, 1));
            if (pick < 55) begin
                cur_tick = cur_tick + $urandom_range(1, 400);
                b.tick = cur_tick;
            end else if (pick < 90) begin
                b.action = ACTION_CHECK;
                case ($urandom_range(0, 3))
                    0: gap = loss_thr + $urandom_range(0, 4) - 2;
                    1: gap = off_thr + $urandom_range(0, 4) - 2;
                    2: gap = $urandom_range(0, 4000);
                    default: gap = $urandom;
                endcase
                b.tick = last_pkt_tick + gap;
                cur_tick = b.tick;
            end else begin
                // noise: any action at any tick
                b.action = 1'($urandom_range(0, 1));
                b.tick = $urandom;
                cur_tick = b.tick;
            end
            send_beat(b, 1'b0, '0);
            sender_gap();
        end
    endtask

    // compare one result field
    task automatic cmp_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // result checker
    always @(posedge aclk) begin : result_monitor
        setpoint_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (setpoint_q.size() == 0) begin
                $error("result beat with no pending expectation");
                mismatches++;
            end else begin
                want = setpoint_q.pop_front();
                cmp_field("setpoint_valid", want.valid, m_tuser);
                cmp_field("setpoint_tick", want.tick, m_tdata[31:0]);
                cmp_field("throttle_out", want.thr, $signed(m_tdata[47:32]));
                cmp_field("roll_degrees", want.roll, $signed(m_tdata[64:48]));
                cmp_field("pitch_degrees", want.pitch, $signed(m_tdata[81:65]));
                cmp_field("yaw_rate", want.yaw, $signed(m_tdata[97:82]));
                cmp_field("motors_enabled", want.motors, m_tdata[98]);
                cmp_field("failsafe_phase", want.phase, m_tdata[100:99]);
            end
        end
    end

    // receiver: short stall bursts, plus one long hold on request
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_cnt = LONG_HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                hold_cnt = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // stimulus
    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        mismatches = 0;
        calm = 1'b0;
        long_hold_req = 1'b0;
        cur_tick = 32'd0;
        loss_thr = LOSS_THRESHOLD_RST;
        off_thr = SWITCHOFF_THRESHOLD_RST;
        roll_full = MAX_ANGLE_RST;
        pitch_full = MAX_ANGLE_RST;
        fs_phase = PHASE_OFF;
        last_pkt_tick = 32'd0;
        sw_latched = 1'b0;
        motors_on = 1'b0;

        // directed table at reset settings
        // check right after reset: switched off, nothing happens
        row(mk_beat(ACTION_CHECK, 32'd5000, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(0, 0, 0, 0, 0, 0, 0, PHASE_OFF));
        row(mk_beat(ACTION_PACKET, 32'd100, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(1, 100, 0, 0, 0, 0, 0, PHASE_IDLE));
        // full positive sticks, switch pressed
        row(mk_beat(ACTION_PACKET, 32'd200, 32767, 32767, 32767, 32767, 1), 1'b0, '0);
        // full negative sticks, switch released: motors on
        row(mk_beat(ACTION_PACKET, 32'd300, -32768, -32768, -32768, -32768, 0), 1'b1,
            mk_sp(1, 300, -32768, -5120, -5120, -32768, 1, PHASE_IDLE));
        // gap equal to the loss threshold is still fine
        row(mk_beat(ACTION_CHECK, 32'd1800, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(0, 0, 0, 0, 0, 0, 1, PHASE_IDLE));
        row(mk_beat(ACTION_CHECK, 32'd1801, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(1, 1801, 0, 0, 0, 0, 1, PHASE_LOSS));
        row(mk_beat(ACTION_CHECK, 32'd3299, 0, 0, 0, 0, 0), 1'b0, '0);
        // gap reaches switch-off: motors off
        row(mk_beat(ACTION_CHECK, 32'd3300, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(0, 0, 0, 0, 0, 0, 0, PHASE_OFF));
        row(mk_beat(ACTION_CHECK, 32'd9000, 0, 0, 0, 0, 0), 1'b1,
            mk_sp(0, 0, 0, 0, 0, 0, 0, PHASE_OFF));
        // tick wrap around the last packet
        row(mk_beat(ACTION_PACKET, 32'hFFFF_FF00, 1, 1, -1, 1, 1), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'hFFFF_FFF0, -1, 16384, -16384, -1, 1), 1'b0, '0);
        row(mk_beat(ACTION_CHECK, 32'h0000_05CC, 0, 0, 0, 0, 0), 1'b0, '0);
        row(mk_beat(ACTION_CHECK, 32'h0000_05CD, 0, 0, 0, 0, 0), 1'b0, '0);
        // release after a held switch
        row(mk_beat(ACTION_PACKET, 32'h0000_0700, 28672, 4660, -12345, 16384, 0), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'h0000_0701, -28672, -4660, 12345, -16384, 0), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'h0000_0702, 100, 21845, -21845, 21845, 1), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'h0000_0703, -100, -21845, 21845, -21845, 0), 1'b0, '0);
        row(mk_beat(ACTION_CHECK, 32'h0000_0703, 0, 0, 0, 0, 1), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'd0, 0, 0, 0, 0, 0), 1'b0, '0);
        row(mk_beat(ACTION_PACKET, 32'hFFFF_FFFF, 32767, -32768, 32767, -32768, 0), 1'b0, '0);
        row(mk_beat(ACTION_CHECK, 32'h0000_05DC, -1, -1, -1, -1, 1), 1'b0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i]) begin
            send_beat(dir_tab[i].beat, dir_tab[i].typed, dir_tab[i].want);
            sender_gap();
        end
        drain();

        // register settings, each followed by random traffic
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    cfg_write(CFG_LOSS_THRESHOLD, 32'd0);
                    cfg_write(CFG_SWITCHOFF_THRESHOLD, 32'd0);
                    cfg_write(CFG_ROLL_MAX_ANGLE, 32'd0);
                    cfg_write(CFG_PITCH_MAX_ANGLE, 32'h0000_FFFF);
                end
                1: begin
                    cfg_write(CFG_LOSS_THRESHOLD, 32'hFFFF_FFFF);
                    cfg_write(CFG_SWITCHOFF_THRESHOLD, 32'hFFFF_FFFF);
                    cfg_write(CFG_ROLL_MAX_ANGLE, 32'hFFFF_FFFF);
                    cfg_write(CFG_PITCH_MAX_ANGLE, 32'hFFFF_0000);
                    cfg_write(8'(CFG_FIRST_UNMAPPED + $urandom_range(0, 251)), $urandom);
                end
                2: begin
                    cfg_write(CFG_LOSS_THRESHOLD, 32'd0);
                    cfg_write(CFG_SWITCHOFF_THRESHOLD, 32'hFFFF_FFFF);
                    cfg_write(CFG_ROLL_MAX_ANGLE, $urandom);
                    cfg_write(CFG_PITCH_MAX_ANGLE, $urandom);
                end
                3: begin
                    cfg_write(CFG_LOSS_THRESHOLD, $urandom);
                    cfg_write(CFG_SWITCHOFF_THRESHOLD, $urandom);
                    cfg_write(CFG_ROLL_MAX_ANGLE, $urandom);
                    cfg_write(CFG_PITCH_MAX_ANGLE, $urandom);
                    cfg_write(8'hFF, $urandom);
                end
                default: begin
                    cfg_write(CFG_LOSS_THRESHOLD, $urandom_range(0, 2000));
                    cfg_write(CFG_SWITCHOFF_THRESHOLD, loss_thr + $urandom_range(0, 2500));
                    cfg_write(CFG_ROLL_MAX_ANGLE, $urandom_range(0, 65535));
                    cfg_write(CFG_PITCH_MAX_ANGLE, $urandom_range(0, 65535));
                end
            endcase
            cfg_valid <= 1'b0;
            // back up the input once while the sender keeps offering
            if (ph == 4) long_hold_req = 1'b1;
            if (ph == 7) calm = 1'b1;
            run_random(75);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcfs_pkg.sv
rtl/rcfs_ctrl.sv
rtl/rcfs_dp.sv
rtl/rc_failsafe_and_stick_mapper.sv
verif/tb_rc_failsafe_and_stick_mapper.sv
